// ===== sv/rotation_matrix_to_quaternion_assert.svh =====
// Assertion macros shared by the quaternion converter.
// Each macro expects clk and rst_n to be in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles
`define RMQ_ASSERT_LAT(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== sv/rmq_pkg.sv =====
package rmq_pkg;

  // Element and result formats
  localparam int ELEM_WIDTH = 16;
  localparam int OUT_WIDTH  = 16;
  localparam int OUT_FRAC   = 14;
  localparam int VEC_WIDTH  = ELEM_WIDTH + 2;
  localparam int MAG_WIDTH  = VEC_WIDTH;

  // Normalization and root/divide datapath
  localparam int NORM_WIDTH = 30;
  localparam int SQ_WIDTH   = 2 * NORM_WIDTH + 2;
  localparam int ROOT_WIDTH = SQ_WIDTH / 2;
  localparam int ISQ_STAGES = ROOT_WIDTH;
  localparam int QUO_WIDTH  = OUT_FRAC + 1;
  localparam int NUM_WIDTH  = NORM_WIDTH + OUT_FRAC + 1;
  localparam int DIV_STAGES = QUO_WIDTH + 1;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_r1c1;
    logic signed [ELEM_WIDTH-1:0] elem_r1c2;
    logic signed [ELEM_WIDTH-1:0] elem_r1c3;
    logic signed [ELEM_WIDTH-1:0] elem_r2c1;
    logic signed [ELEM_WIDTH-1:0] elem_r2c2;
    logic signed [ELEM_WIDTH-1:0] elem_r2c3;
    logic signed [ELEM_WIDTH-1:0] elem_r3c1;
    logic signed [ELEM_WIDTH-1:0] elem_r3c2;
    logic signed [ELEM_WIDTH-1:0] elem_r3c3;
  } rmq_req_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] quat_w;
    logic signed [OUT_WIDTH-1:0] quat_x;
    logic signed [OUT_WIDTH-1:0] quat_y;
    logic signed [OUT_WIDTH-1:0] quat_z;
    logic [1:0]                  case_used;
    logic                        bad_input;
  } rmq_resp_t;

endpackage

// ===== sv/rmq_isqrt.sv =====
module rmq_isqrt
  import rmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [SQ_WIDTH-1:0]   in_rad,
  output logic                  out_valid,
  output logic [ROOT_WIDTH-1:0] out_root
);

  localparam int REM_W = ROOT_WIDTH + 2;

  logic                  vld_r  [ISQ_STAGES];
  logic [REM_W-1:0]      rem_r  [ISQ_STAGES];
  logic [ROOT_WIDTH-1:0] root_r [ISQ_STAGES];
  logic [SQ_WIDTH-1:0]   src_r  [ISQ_STAGES];

  logic                  vld_in  [ISQ_STAGES];
  logic [REM_W-1:0]      rem_in  [ISQ_STAGES];
  logic [ROOT_WIDTH-1:0] root_in [ISQ_STAGES];
  logic [SQ_WIDTH-1:0]   src_in  [ISQ_STAGES];

  logic [REM_W-1:0]      rem_nxt  [ISQ_STAGES];
  logic [ROOT_WIDTH-1:0] root_nxt [ISQ_STAGES];

  // One result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign vld_in[k]  = in_valid;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign src_in[k]  = in_rad;
    end else begin : g_next
      assign vld_in[k]  = vld_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign src_in[k]  = src_r[k-1];
    end

    assign rem_sh = {rem_in[k][REM_W-3:0], src_in[k][SQ_WIDTH-1 -: 2]};
    assign trial  = {root_in[k], 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_nxt[k]  = rem_sh - trial;
        root_nxt[k] = {root_in[k][ROOT_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh;
        root_nxt[k] = {root_in[k][ROOT_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      src_r[k]  <= {src_in[k][SQ_WIDTH-3:0], 2'b00};
    end
  end

  assign out_valid = vld_r[ISQ_STAGES-1];
  assign out_root  = root_r[ISQ_STAGES-1];

endmodule

// ===== sv/rmq_div.sv =====
module rmq_div
  import rmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [NORM_WIDTH-1:0] in_mag,
  input  logic [ROOT_WIDTH-1:0] in_len,
  output logic                  out_valid,
  output logic [QUO_WIDTH-1:0]  out_quo
);

  localparam int RW = ROOT_WIDTH + 1;

  logic                  vld_r [DIV_STAGES];
  logic [NUM_WIDTH-1:0]  num_r [DIV_STAGES];
  logic [ROOT_WIDTH-1:0] len_r [DIV_STAGES];
  logic [RW-1:0]         rem_r [DIV_STAGES];
  logic [QUO_WIDTH-1:0]  quo_r [DIV_STAGES];

  logic [NUM_WIDTH-1:0]  num_nxt;

  // Rounded numerator: mag * 2^14 + len / 2
  assign num_nxt = {in_mag, {OUT_FRAC{1'b0}}, 1'b0} >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  // Quotient fits in QUO_WIDTH bits, so the high part starts below len
  always_ff @(posedge clk) begin
    num_r[0] <= num_nxt + NUM_WIDTH'(in_len >> 1);
    len_r[0] <= in_len;
    rem_r[0] <= '0;
    quo_r[0] <= '0;
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] rem_nxt;
    logic          bit_nxt;

    if (j == 1) begin : g_first
      assign rem_sh = {{(RW + QUO_WIDTH - NUM_WIDTH - 1){1'b0}},
                       num_r[0][NUM_WIDTH-1:QUO_WIDTH-1]};
    end else begin : g_next
      assign rem_sh = {rem_r[j-1][RW-2:0], num_r[j-1][QUO_WIDTH-j]};
    end

    always_comb begin
      if (rem_sh >= {1'b0, len_r[j-1]}) begin
        rem_nxt = rem_sh - {1'b0, len_r[j-1]};
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = rem_sh;
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      num_r[j] <= num_r[j-1];
      len_r[j] <= len_r[j-1];
      rem_r[j] <= rem_nxt;
      quo_r[j] <= {quo_r[j-1][QUO_WIDTH-2:0], bit_nxt};
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, Shepperd's method, Q2.14 fixed point.
// Input: assert start with a 3x3 matrix on in_req for one cycle; busy is
// never raised, so a new request may be issued every clock cycle.
// Output: out_valid strobes for one cycle with w,x,y,z, the case used and
// the bad-input flag on out_resp; the receiver must take it in that cycle.
// Configuration: cfg_we with cfg_wdata writes the transposed-layout bit;
// write it only while no request is in flight.
// Pipeline: 9 front stages (case select, magnitudes, normalize, squares,
// sum), 31 stages of the bit-per-stage square root, 16 stages of the
// bit-per-stage divider (one per quotient bit plus the rounding add) and
// the output register. Throughput: one request per cycle.
// Bad input (non-positive radicand or zero vector) returns the identity
// quaternion with bad_input set.
// Reset: clears all stage valid bits and the layout bit; requests in
// flight are dropped.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rmq_req_t  in_req,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output logic      out_valid,
  output rmq_resp_t out_resp
);

  `include "rotation_matrix_to_quaternion_assert.svh"

  localparam int PW      = $clog2(MAG_WIDTH + 1);
  localparam int LATENCY = 9 + ISQ_STAGES + DIV_STAGES + 1;
  localparam logic signed [VEC_WIDTH-1:0] ONE = VEC_WIDTH'(1) <<< (ELEM_WIDTH - 2);
  localparam logic signed [OUT_WIDTH-1:0] Q_ONE = OUT_WIDTH'(1) <<< OUT_FRAC;

  typedef struct packed {
    case_t      which;
    logic       bad;
    logic [3:0] neg;
  } meta_t;

  // Bit index of the leading one
  function automatic logic [PW-1:0] msb_pos(input logic [MAG_WIDTH-1:0] val);
    logic [PW-1:0] pos;
    pos = '0;
    for (int b = 0; b < MAG_WIDTH; b++) begin
      if (val[b]) pos = PW'(b);
    end
    return pos;
  endfunction

  logic transposed_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transposed_r <= 1'b0;
    end else if (cfg_we) begin
      transposed_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // ---------------- Stage 1: layout, trace, case select ----------------
  logic signed [VEC_WIDTH-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  logic signed [VEC_WIDTH-1:0] t_sum;
  logic signed [VEC_WIDTH-1:0] m_r [9];
  logic signed [VEC_WIDTH-1:0] t1_r;
  case_t which_nxt, which1_r;
  logic  v1_r;

  always_comb begin
    e11 = VEC_WIDTH'(in_req.elem_r1c1);
    e22 = VEC_WIDTH'(in_req.elem_r2c2);
    e33 = VEC_WIDTH'(in_req.elem_r3c3);
    e12 = VEC_WIDTH'(transposed_r ? in_req.elem_r2c1 : in_req.elem_r1c2);
    e21 = VEC_WIDTH'(transposed_r ? in_req.elem_r1c2 : in_req.elem_r2c1);
    e13 = VEC_WIDTH'(transposed_r ? in_req.elem_r3c1 : in_req.elem_r1c3);
    e31 = VEC_WIDTH'(transposed_r ? in_req.elem_r1c3 : in_req.elem_r3c1);
    e23 = VEC_WIDTH'(transposed_r ? in_req.elem_r3c2 : in_req.elem_r2c3);
    e32 = VEC_WIDTH'(transposed_r ? in_req.elem_r2c3 : in_req.elem_r3c2);
    t_sum = ONE + e11 + e22 + e33;
    if (t_sum > 0) begin
      which_nxt = CASE_TRACE;
    end else if (e11 >= e22 && e11 >= e33) begin
      which_nxt = CASE_X;
    end else if (e22 >= e11 && e22 >= e33) begin
      which_nxt = CASE_Y;
    end else begin
      which_nxt = CASE_Z;
    end
  end

  always_ff @(posedge clk) begin
    m_r[0] <= e11; m_r[1] <= e12; m_r[2] <= e13;
    m_r[3] <= e21; m_r[4] <= e22; m_r[5] <= e23;
    m_r[6] <= e31; m_r[7] <= e32; m_r[8] <= e33;
    t1_r     <= t_sum;
    which1_r <= which_nxt;
  end

  // ---------------- Stage 2: unnormalized vector ----------------
  logic signed [VEC_WIDTH-1:0] vec_nxt [4];
  logic signed [VEC_WIDTH-1:0] rad_nxt;
  logic signed [VEC_WIDTH-1:0] vec2_r  [4];
  logic                        radpos2_r;
  case_t which2_r;
  logic  v2_r;

  always_comb begin
    case (which1_r)
      CASE_TRACE: begin
        rad_nxt    = t1_r;
        vec_nxt[0] = t1_r;
        vec_nxt[1] = m_r[7] - m_r[5];
        vec_nxt[2] = m_r[2] - m_r[6];
        vec_nxt[3] = m_r[3] - m_r[1];
      end
      CASE_X: begin
        rad_nxt    = ONE + m_r[0] - m_r[4] - m_r[8];
        vec_nxt[0] = m_r[7] - m_r[5];
        vec_nxt[1] = rad_nxt;
        vec_nxt[2] = m_r[3] + m_r[1];
        vec_nxt[3] = m_r[2] + m_r[6];
      end
      CASE_Y: begin
        rad_nxt    = ONE - m_r[0] + m_r[4] - m_r[8];
        vec_nxt[0] = m_r[2] - m_r[6];
        vec_nxt[1] = m_r[3] + m_r[1];
        vec_nxt[2] = rad_nxt;
        vec_nxt[3] = m_r[7] + m_r[5];
      end
      default: begin
        rad_nxt    = ONE - m_r[0] - m_r[4] + m_r[8];
        vec_nxt[0] = m_r[3] - m_r[1];
        vec_nxt[1] = m_r[2] + m_r[6];
        vec_nxt[2] = m_r[7] + m_r[5];
        vec_nxt[3] = rad_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    vec2_r    <= vec_nxt;
    radpos2_r <= rad_nxt > 0;
    which2_r  <= which1_r;
  end

  // ---------------- Stage 3: signs and magnitudes ----------------
  logic [MAG_WIDTH-1:0] mag3_r [4];
  meta_t meta3_r;
  logic  v3_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      meta3_r.neg[i] <= vec2_r[i][VEC_WIDTH-1];
      mag3_r[i]      <= vec2_r[i][VEC_WIDTH-1] ? MAG_WIDTH'(-vec2_r[i])
                                                : MAG_WIDTH'(vec2_r[i]);
    end
    meta3_r.which <= which2_r;
    meta3_r.bad   <= !radpos2_r;
  end

  // ---------------- Stage 4: largest magnitude ----------------
  logic [MAG_WIDTH-1:0] max_a, max_b, max_nxt;
  logic [MAG_WIDTH-1:0] mag4_r [4];
  logic [MAG_WIDTH-1:0] max4_r;
  meta_t meta4_nxt;
  meta_t meta4_r;
  logic  v4_r;

  assign max_a   = (mag3_r[0] > mag3_r[1]) ? mag3_r[0] : mag3_r[1];
  assign max_b   = (mag3_r[2] > mag3_r[3]) ? mag3_r[2] : mag3_r[3];
  assign max_nxt = (max_a > max_b) ? max_a : max_b;

  // All-zero vector also flags bad input
  always_comb begin
    meta4_nxt     = meta3_r;
    meta4_nxt.bad = meta3_r.bad || (max_nxt == '0);
  end

  always_ff @(posedge clk) begin
    mag4_r  <= mag3_r;
    max4_r  <= max_nxt;
    meta4_r <= meta4_nxt;
  end

  // ---------------- Stage 5: leading-one position ----------------
  logic [MAG_WIDTH-1:0] mag5_r [4];
  logic [PW-1:0]        pos5_r;
  meta_t meta5_r;
  logic  v5_r;

  always_ff @(posedge clk) begin
    mag5_r  <= mag4_r;
    pos5_r  <= msb_pos(max4_r);
    meta5_r <= meta4_r;
  end

  // ---------------- Stage 6: normalize to [2^29, 2^30) ----------------
  logic [NORM_WIDTH-1:0] norm6_r [4];
  meta_t meta6_r;
  logic  v6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      norm6_r[i] <= NORM_WIDTH'({mag5_r[i], {NORM_WIDTH{1'b0}}} >> (pos5_r + PW'(1)));
    end
    meta6_r <= meta5_r;
  end

  // ---------------- Stage 7: squares ----------------
  logic [2*NORM_WIDTH-1:0] sq7_r   [4];
  logic [NORM_WIDTH-1:0]   norm7_r [4];
  meta_t meta7_r;
  logic  v7_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq7_r[i] <= norm6_r[i] * norm6_r[i];
    end
    norm7_r <= norm6_r;
    meta7_r <= meta6_r;
  end

  // ---------------- Stage 8: pair sums ----------------
  logic [SQ_WIDTH-1:0]   ps8_r   [2];
  logic [NORM_WIDTH-1:0] norm8_r [4];
  meta_t meta8_r;
  logic  v8_r;

  always_ff @(posedge clk) begin
    ps8_r[0] <= SQ_WIDTH'(sq7_r[0]) + SQ_WIDTH'(sq7_r[1]);
    ps8_r[1] <= SQ_WIDTH'(sq7_r[2]) + SQ_WIDTH'(sq7_r[3]);
    norm8_r  <= norm7_r;
    meta8_r  <= meta7_r;
  end

  // ---------------- Stage 9: sum of squares ----------------
  logic [SQ_WIDTH-1:0]   sum9_r;
  logic [NORM_WIDTH-1:0] norm9_r [4];
  meta_t meta9_r;
  logic  v9_r;

  always_ff @(posedge clk) begin
    sum9_r  <= ps8_r[0] + ps8_r[1];
    norm9_r <= norm8_r;
    meta9_r <= meta8_r;
  end

  // Front-end valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
      v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  // ---------------- Vector length ----------------
  logic                  len_vld;
  logic [ROOT_WIDTH-1:0] len;

  rmq_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v9_r),
    .in_rad    (sum9_r),
    .out_valid (len_vld),
    .out_root  (len)
  );

  // Magnitudes and metadata ride alongside the root
  logic [NORM_WIDTH-1:0] dmag_r  [ISQ_STAGES][4];
  meta_t                 dmeta_r [ISQ_STAGES];

  always_ff @(posedge clk) begin
    dmag_r[0]  <= norm9_r;
    dmeta_r[0] <= meta9_r;
    for (int s = 1; s < ISQ_STAGES; s++) begin
      dmag_r[s]  <= dmag_r[s-1];
      dmeta_r[s] <= dmeta_r[s-1];
    end
  end

  // ---------------- Per-component rounded divide ----------------
  logic [3:0]           div_vld;
  logic [QUO_WIDTH-1:0] quo [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    rmq_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (len_vld),
      .in_mag    (dmag_r[ISQ_STAGES-1][g]),
      .in_len    (len),
      .out_valid (div_vld[g]),
      .out_quo   (quo[g])
    );
  end

  meta_t qmeta_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    qmeta_r[0] <= dmeta_r[ISQ_STAGES-1];
    for (int s = 1; s < DIV_STAGES; s++) begin
      qmeta_r[s] <= qmeta_r[s-1];
    end
  end

  // ---------------- Output register ----------------
  logic signed [OUT_WIDTH-1:0] comp [4];
  meta_t     fin_meta;
  rmq_resp_t resp_nxt;
  rmq_resp_t out_resp_r;
  logic      out_valid_r;

  // Quotient never exceeds 2^14, so the signed result needs no clamp
  always_comb begin
    fin_meta = qmeta_r[DIV_STAGES-1];
    for (int i = 0; i < 4; i++) begin
      comp[i] = fin_meta.neg[i] ? -OUT_WIDTH'(quo[i]) : OUT_WIDTH'(quo[i]);
    end
    resp_nxt.case_used = fin_meta.which;
    resp_nxt.bad_input = fin_meta.bad;
    if (fin_meta.bad) begin
      resp_nxt.quat_w = Q_ONE;
      resp_nxt.quat_x = '0;
      resp_nxt.quat_y = '0;
      resp_nxt.quat_z = '0;
    end else begin
      resp_nxt.quat_w = comp[0];
      resp_nxt.quat_x = comp[1];
      resp_nxt.quat_y = comp[2];
      resp_nxt.quat_z = comp[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    out_resp_r <= resp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  // ---------------- Assertions ----------------
  // w may round to zero in the trace case when the trace term is tiny
  `RMQ_ASSERT_IMPL(a_lanes_in_step, div_vld != 4'b0000, div_vld == 4'b1111, "divider lanes out of step")
  `RMQ_ASSERT_LAT(a_latency, start && !busy, LATENCY, out_valid, "request produced no result")
  `RMQ_ASSERT_IMPL(a_bad_identity, out_valid && out_resp.bad_input, out_resp.quat_w == Q_ONE && out_resp.quat_x == '0 && out_resp.quat_y == '0 && out_resp.quat_z == '0, "bad input not identity")
  `RMQ_ASSERT_IMPL(a_trace_w_pos, out_valid && !out_resp.bad_input && out_resp.case_used == CASE_TRACE, out_resp.quat_w >= 0, "trace case gave negative w")

endmodule
